FILE: hdl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared constants, codes and types of the breakpoint table manager.
// ----------------------------------------------------------------------------
package bpt_pkg;

  // Table geometry
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // Most memory writes one request may issue
  localparam int MAX_OUT   = 16;
  localparam int WCNT_W    = $clog2(MAX_OUT + 1);

  localparam logic [7:0] TRAP_OPCODE = 8'hCC;

  // Highest supported breakpoint kind (hardware execution)
  localparam logic [1:0] KIND_MAX = 2'd1;

  typedef enum logic [3:0] {
    REQ_ADD     = 4'd0,
    REQ_REMOVE  = 4'd1,
    REQ_LOOKUP  = 4'd2,
    REQ_INSERT  = 4'd3,
    REQ_RESTORE = 4'd4,
    REQ_PREPARE = 4'd5,
    REQ_FINISH  = 4'd6,
    REQ_CANCEL  = 4'd7,
    REQ_SETAUTO = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_BAD_KIND  = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_FIN
  } state_t;

  // Update command into the slot table
  typedef struct packed {
    logic              fill;       // load address and byte, mark live and patched
    logic              set_patch;  // write patched flag with patch_val
    logic              patch_val;
    logic              kill;       // clear live and patched
    logic [SLOT_W-1:0] idx;
    logic [31:0]       addr;
    logic [7:0]        data;
  } tbl_wr_t;

  // One slot as read from the table
  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  data;
    logic        live;
    logic        patched;
  } tbl_rd_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic        hit;
    logic [3:0]  hit_index;
    logic        wr_valid;
    logic [31:0] wr_addr;
    logic [7:0]  wr_data;
    logic        resume_pending;
    logic        auto_resume;
    logic        last;
  } rsp_t;

endpackage

FILE: hdl/bpt_if.sv
// ----------------------------------------------------------------------------
// bpt_if
// Request and result channels of the breakpoint table manager.
// ----------------------------------------------------------------------------
interface bpt_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [31:0] target_addr;
  logic [1:0]  bp_kind;
  logic [7:0]  orig_byte_in;
  logic        auto_flag_in;

  modport source (output valid, req_type, target_addr, bp_kind, orig_byte_in,
                  auto_flag_in, input ready);
  modport sink   (input valid, req_type, target_addr, bp_kind, orig_byte_in,
                  auto_flag_in, output ready);
endinterface

interface bpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [3:0]  hit_index;
  logic        wr_valid;
  logic [31:0] wr_addr;
  logic [7:0]  wr_data;
  logic        resume_pending;
  logic        auto_resume;
  logic        last;

  modport source (output valid, status, hit, hit_index, wr_valid, wr_addr, wr_data,
                  resume_pending, auto_resume, last, input ready);
  modport sink   (input valid, status, hit, hit_index, wr_valid, wr_addr, wr_data,
                  resume_pending, auto_resume, last, output ready);
endinterface

FILE: hdl/bpt_table.sv
// ----------------------------------------------------------------------------
// bpt_table
// Slot storage: address and saved byte per slot, live and patched flags.
// rd_idx names the slot that rd presents in the following cycle.
// ----------------------------------------------------------------------------
module bpt_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpt_pkg::tbl_wr_t              wr,
  input  logic [bpt_pkg::SLOT_W-1:0]    rd_idx,
  output bpt_pkg::tbl_rd_t              rd
);

  logic [31:0]                   slot_addr_r [bpt_pkg::NUM_SLOTS];
  logic [7:0]                    slot_byte_r [bpt_pkg::NUM_SLOTS];
  logic [bpt_pkg::NUM_SLOTS-1:0] live_r;
  logic [bpt_pkg::NUM_SLOTS-1:0] patched_r;
  logic [bpt_pkg::SLOT_W-1:0]    rd_idx_r;
  logic [31:0]                   rd_addr_r;
  logic [7:0]                    rd_byte_r;

  // Load slot payload on fill and register the read; only ever used once the
  // slot is live
  always_ff @(posedge clk) begin
    if (wr.fill) begin
      slot_addr_r[wr.idx] <= wr.addr;
      slot_byte_r[wr.idx] <= wr.data;
    end
    rd_idx_r  <= rd_idx;
    rd_addr_r <= slot_addr_r[rd_idx];
    rd_byte_r <= slot_byte_r[rd_idx];
  end

  // Update the slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      patched_r <= '0;
    end else begin
      if (wr.fill) begin
        live_r[wr.idx]    <= 1'b1;
        patched_r[wr.idx] <= 1'b1;
      end
      if (wr.set_patch) begin
        patched_r[wr.idx] <= wr.patch_val;
      end
      if (wr.kill) begin
        live_r[wr.idx]    <= 1'b0;
        patched_r[wr.idx] <= 1'b0;
      end
    end
  end

  // Present the selected slot with its current flags
  assign rd.addr    = rd_addr_r;
  assign rd.data    = rd_byte_r;
  assign rd.live    = live_r[rd_idx_r];
  assign rd.patched = patched_r[rd_idx_r];

endmodule

FILE: hdl/breakpoint_table_manager.sv
// ----------------------------------------------------------------------------
// breakpoint_table_manager
// Software breakpoint table that patches memory with a one-byte trap opcode.
// ----------------------------------------------------------------------------
// One request is taken at a time. Add, remove, look up and prepare resume walk
// the used slots with a single address comparator, one slot per clock, and
// stop at the first live match; insert all and restore all walk every used
// slot the same way, except that they hold on a slot while a stalled result
// side keeps the previous write from leaving. Every memory byte write leaves
// as one result item in slot order, a request without writes gives one item,
// and the final item carries last. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module breakpoint_table_manager (
  input  logic         clk,
  input  logic         rst_n,
  bpt_req_if.sink      in_req,
  bpt_rsp_if.source    out_rsp
);

  bpt_pkg::state_t                  state_r, state_nxt;
  bpt_pkg::req_t                    req_r, req_nxt;
  logic [31:0]                      addr_r, addr_nxt;
  logic [1:0]                       kind_r, kind_nxt;
  logic [7:0]                       byte_r, byte_nxt;
  logic                             flag_r, flag_nxt;
  logic [bpt_pkg::CNT_W-1:0]        scan_r, scan_nxt;
  logic [bpt_pkg::CNT_W-1:0]        used_r, used_nxt;
  logic                             found_r, found_nxt;
  logic [bpt_pkg::SLOT_W-1:0]       match_r, match_nxt;
  logic                             free_found_r, free_found_nxt;
  logic [bpt_pkg::SLOT_W-1:0]       free_r, free_nxt;
  logic                             pend_r, pend_nxt;
  logic [bpt_pkg::SLOT_W-1:0]       pslot_r, pslot_nxt;
  logic                             auto_r, auto_nxt;
  bpt_pkg::status_t                 status_r, status_nxt;
  logic                             hit_r, hit_nxt;
  logic [bpt_pkg::SLOT_W-1:0]       hidx_r, hidx_nxt;
  logic                             held_v_r, held_v_nxt;
  logic [31:0]                      held_addr_r, held_addr_nxt;
  logic [7:0]                       held_data_r, held_data_nxt;
  logic [bpt_pkg::WCNT_W-1:0]       wcnt_r, wcnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  bpt_pkg::rsp_t                    out_r, out_nxt;

  bpt_pkg::tbl_wr_t                 tbl_wr;
  bpt_pkg::tbl_rd_t                 tbl_rd;
  logic [bpt_pkg::SLOT_W-1:0]       rd_idx;
  logic                             in_take;
  logic                             out_free;

  bpt_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .rd_idx (rd_idx),
    .rd     (tbl_rd)
  );

  assign in_req.ready = (state_r == bpt_pkg::S_IDLE);
  assign in_take      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // Address the slot needed next cycle: slot 0 or the pending slot when a
  // request is taken, else the next scan position, which stays on a match
  always_comb begin
    if (state_r == bpt_pkg::S_IDLE) begin
      rd_idx = (in_req.req_type == bpt_pkg::REQ_FINISH) ? pslot_r : '0;
    end else begin
      rd_idx = scan_nxt[bpt_pkg::SLOT_W-1:0];
    end
  end

  // Sequencer: next state, table updates and result items
  always_comb begin
    logic                       scan_end;
    logic                       qualify;
    logic                       do_fill;
    logic [bpt_pkg::SLOT_W-1:0] fill_idx;

    state_nxt      = state_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    kind_nxt       = kind_r;
    byte_nxt       = byte_r;
    flag_nxt       = flag_r;
    scan_nxt       = scan_r;
    used_nxt       = used_r;
    found_nxt      = found_r;
    match_nxt      = match_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    pend_nxt       = pend_r;
    pslot_nxt      = pslot_r;
    auto_nxt       = auto_r;
    status_nxt     = status_r;
    hit_nxt        = hit_r;
    hidx_nxt       = hidx_r;
    held_v_nxt     = held_v_r;
    held_addr_nxt  = held_addr_r;
    held_data_nxt  = held_data_r;
    wcnt_nxt       = wcnt_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_nxt        = out_r;
    tbl_wr         = '0;
    scan_end       = (scan_r == used_r);
    qualify        = 1'b0;
    do_fill        = 1'b0;
    fill_idx       = '0;

    case (state_r)
      // Take a request and clear the per-request results
      bpt_pkg::S_IDLE: begin
        if (in_take) begin
          req_nxt        = bpt_pkg::req_t'(in_req.req_type);
          addr_nxt       = in_req.target_addr;
          kind_nxt       = in_req.bp_kind;
          byte_nxt       = in_req.orig_byte_in;
          flag_nxt       = in_req.auto_flag_in;
          scan_nxt       = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          status_nxt     = bpt_pkg::STS_OK;
          hit_nxt        = 1'b0;
          hidx_nxt       = '0;
          held_v_nxt     = 1'b0;
          wcnt_nxt       = '0;
          if (in_req.req_type inside {bpt_pkg::REQ_ADD, bpt_pkg::REQ_REMOVE,
                                      bpt_pkg::REQ_LOOKUP, bpt_pkg::REQ_INSERT,
                                      bpt_pkg::REQ_RESTORE, bpt_pkg::REQ_PREPARE}) begin
            state_nxt = bpt_pkg::S_SCAN;
          end else begin
            state_nxt = bpt_pkg::S_ACT;
          end
        end
      end

      // Walk the used slots, one per cycle unless a held write cannot leave
      bpt_pkg::S_SCAN: begin
        if (req_r == bpt_pkg::REQ_INSERT || req_r == bpt_pkg::REQ_RESTORE) begin
          qualify = tbl_rd.live && (tbl_rd.addr != 32'd0) &&
                    ((req_r == bpt_pkg::REQ_INSERT) ? !tbl_rd.patched : tbl_rd.patched);
          if (scan_end || wcnt_r == bpt_pkg::WCNT_W'(bpt_pkg::MAX_OUT)) begin
            state_nxt = bpt_pkg::S_FIN;
          end else if (qualify) begin
            // Hold off while the previous write cannot leave
            if (!held_v_r || out_free) begin
              if (held_v_r) begin
                out_valid_nxt          = 1'b1;
                out_nxt.status         = status_r;
                out_nxt.hit            = hit_r;
                out_nxt.hit_index      = 4'(hidx_r);
                out_nxt.wr_valid       = 1'b1;
                out_nxt.wr_addr        = held_addr_r;
                out_nxt.wr_data        = held_data_r;
                out_nxt.resume_pending = pend_r;
                out_nxt.auto_resume    = auto_r;
                out_nxt.last           = 1'b0;
              end
              held_v_nxt       = 1'b1;
              held_addr_nxt    = tbl_rd.addr;
              held_data_nxt    = (req_r == bpt_pkg::REQ_INSERT) ? bpt_pkg::TRAP_OPCODE
                                                                : tbl_rd.data;
              tbl_wr.set_patch = 1'b1;
              tbl_wr.patch_val = (req_r == bpt_pkg::REQ_INSERT);
              tbl_wr.idx       = scan_r[bpt_pkg::SLOT_W-1:0];
              wcnt_nxt         = wcnt_r + 1'b1;
              scan_nxt         = scan_r + 1'b1;
            end
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end else begin
          if (scan_end) begin
            state_nxt = bpt_pkg::S_ACT;
          end else if (tbl_rd.live && tbl_rd.addr == addr_r) begin
            found_nxt = 1'b1;
            match_nxt = scan_r[bpt_pkg::SLOT_W-1:0];
            state_nxt = bpt_pkg::S_ACT;
          end else begin
            // Note the first free slot for a possible add
            if (!tbl_rd.live && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_nxt       = scan_r[bpt_pkg::SLOT_W-1:0];
            end
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      // Apply the request to the table
      bpt_pkg::S_ACT: begin
        state_nxt = bpt_pkg::S_FIN;
        case (req_r)
          bpt_pkg::REQ_ADD: begin
            if (found_r) begin
              status_nxt = bpt_pkg::STS_OK;
            end else if (kind_r > bpt_pkg::KIND_MAX) begin
              status_nxt = bpt_pkg::STS_BAD_KIND;
            end else if (free_found_r) begin
              do_fill  = 1'b1;
              fill_idx = free_r;
            end else if (used_r >= bpt_pkg::CNT_W'(bpt_pkg::NUM_SLOTS)) begin
              status_nxt = bpt_pkg::STS_FULL;
            end else begin
              do_fill  = 1'b1;
              fill_idx = used_r[bpt_pkg::SLOT_W-1:0];
              used_nxt = used_r + 1'b1;
            end
            if (do_fill) begin
              tbl_wr.fill   = 1'b1;
              tbl_wr.idx    = fill_idx;
              tbl_wr.addr   = addr_r;
              tbl_wr.data   = byte_r;
              held_v_nxt    = 1'b1;
              held_addr_nxt = addr_r;
              held_data_nxt = bpt_pkg::TRAP_OPCODE;
            end
          end
          bpt_pkg::REQ_REMOVE: begin
            if (!found_r) begin
              status_nxt = bpt_pkg::STS_NOT_FOUND;
            end else begin
              if (tbl_rd.patched) begin
                held_v_nxt    = 1'b1;
                held_addr_nxt = tbl_rd.addr;
                held_data_nxt = tbl_rd.data;
              end
              tbl_wr.kill = 1'b1;
              tbl_wr.idx  = match_r;
              if (pend_r && pslot_r == match_r) begin
                pend_nxt  = 1'b0;
                pslot_nxt = '0;
                auto_nxt  = 1'b0;
              end
            end
          end
          bpt_pkg::REQ_LOOKUP: begin
            if (!found_r) begin
              status_nxt = bpt_pkg::STS_NOT_FOUND;
            end else begin
              hit_nxt  = 1'b1;
              hidx_nxt = match_r;
            end
          end
          bpt_pkg::REQ_PREPARE: begin
            if (!found_r) begin
              status_nxt = bpt_pkg::STS_NOT_FOUND;
            end else begin
              if (tbl_rd.patched) begin
                held_v_nxt       = 1'b1;
                held_addr_nxt    = tbl_rd.addr;
                held_data_nxt    = tbl_rd.data;
                tbl_wr.set_patch = 1'b1;
                tbl_wr.patch_val = 1'b0;
                tbl_wr.idx       = match_r;
              end
              pend_nxt  = 1'b1;
              pslot_nxt = match_r;
              auto_nxt  = 1'b0;
            end
          end
          bpt_pkg::REQ_FINISH: begin
            if (!pend_r) begin
              status_nxt = bpt_pkg::STS_NOT_FOUND;
            end else begin
              if (tbl_rd.live && !tbl_rd.patched) begin
                held_v_nxt       = 1'b1;
                held_addr_nxt    = tbl_rd.addr;
                held_data_nxt    = bpt_pkg::TRAP_OPCODE;
                tbl_wr.set_patch = 1'b1;
                tbl_wr.patch_val = 1'b1;
                tbl_wr.idx       = pslot_r;
              end
              pend_nxt  = 1'b0;
              pslot_nxt = '0;
              auto_nxt  = 1'b0;
            end
          end
          bpt_pkg::REQ_CANCEL: begin
            pend_nxt  = 1'b0;
            pslot_nxt = '0;
            auto_nxt  = 1'b0;
          end
          bpt_pkg::REQ_SETAUTO: begin
            auto_nxt = flag_r;
          end
          default: begin
          end
        endcase
      end

      // Send the final item of the request
      bpt_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = status_r;
          out_nxt.hit            = hit_r;
          out_nxt.hit_index      = 4'(hidx_r);
          out_nxt.wr_valid       = held_v_r;
          out_nxt.wr_addr        = held_v_r ? held_addr_r : 32'd0;
          out_nxt.wr_data        = held_v_r ? held_data_r : 8'd0;
          out_nxt.resume_pending = pend_r;
          out_nxt.auto_resume    = auto_r;
          out_nxt.last           = 1'b1;
          state_nxt              = bpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bpt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpt_pkg::S_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      pslot_r     <= '0;
      auto_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      pslot_r     <= pslot_nxt;
      auto_r      <= auto_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload and working registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    kind_r       <= kind_nxt;
    byte_r       <= byte_nxt;
    flag_r       <= flag_nxt;
    scan_r       <= scan_nxt;
    found_r      <= found_nxt;
    match_r      <= match_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    status_r     <= status_nxt;
    hit_r        <= hit_nxt;
    hidx_r       <= hidx_nxt;
    held_v_r     <= held_v_nxt;
    held_addr_r  <= held_addr_nxt;
    held_data_r  <= held_data_nxt;
    wcnt_r       <= wcnt_nxt;
    out_r        <= out_nxt;
  end

  // Drive the result channel
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_r.status;
  assign out_rsp.hit            = out_r.hit;
  assign out_rsp.hit_index      = out_r.hit_index;
  assign out_rsp.wr_valid       = out_r.wr_valid;
  assign out_rsp.wr_addr        = out_r.wr_addr;
  assign out_rsp.wr_data        = out_r.wr_data;
  assign out_rsp.resume_pending = out_r.resume_pending;
  assign out_rsp.auto_resume    = out_r.auto_resume;
  assign out_rsp.last           = out_r.last;

endmodule

FILE: tb/sv/tb_breakpoint_table_manager.sv
// ----------------------------------------------------------------------------
// tb_breakpoint_table_manager
// Self-checking bench for the breakpoint table manager. Requests go in through
// a queue-fed driver and results are compared one by one against a cycle-free
// model of the slot table, its resume state and the memory writes it issues.
// ----------------------------------------------------------------------------
module tb_breakpoint_table_manager;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes with no defined meaning
  localparam logic [3:0] REQ_UNDEF_LO = 4'h9;
  localparam logic [3:0] REQ_UNDEF_HI = 4'hF;

  localparam int RANDOM_ITEMS = 125;
  localparam int POOL_SIZE    = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [3:0]  code;
    logic [31:0] addr;
    logic [1:0]  kind;
    logic [7:0]  orig;
    logic        flag;
    int          gap;
  } bp_req_t;

  logic clk = 1'b0;
  logic rst_n;

  bpt_req_if req_if ();
  bpt_rsp_if rsp_if ();

  breakpoint_table_manager dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending requests and results still owed by the block
  bp_req_t        item_q[$];
  bpt_pkg::rsp_t  expected_rsp_q[$];

  // Shadow of the breakpoint table
  logic [31:0] tbl_addr    [bpt_pkg::NUM_SLOTS];
  logic [7:0]  tbl_saved   [bpt_pkg::NUM_SLOTS];
  logic        tbl_live    [bpt_pkg::NUM_SLOTS];
  logic        tbl_patched [bpt_pkg::NUM_SLOTS];
  int          tbl_used;
  logic        resume_armed;
  int          resume_slot;
  logic        auto_on;
  logic [31:0] mem_wr_addr_q[$];
  logic [7:0]  mem_wr_data_q[$];

  // Handshake flags and run statistics
  logic req_taken, rsp_taken;
  int   gap_left, stall_left, hold_cnt, hold_reqs, idle_cycles;
  logic hold_done;
  logic no_gap;
  int   err_cnt, n_req, n_rsp, n_writes, n_full, n_bad_kind, n_not_found, n_hits;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_cnt < 40)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    err_cnt++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  function automatic int find_live_slot(input logic [31:0] a);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_live[i] && tbl_addr[i] == a) return i;
    return -1;
  endfunction

  // Arm one slot with the trap byte
  task automatic emit_trap(input int i);
    if (!tbl_live[i] || tbl_patched[i] || mem_wr_addr_q.size() >= bpt_pkg::MAX_OUT) return;
    mem_wr_addr_q.push_back(tbl_addr[i]);
    mem_wr_data_q.push_back(bpt_pkg::TRAP_OPCODE);
    tbl_patched[i] = 1'b1;
  endtask

  // Put the saved byte back in memory
  task automatic emit_restore(input int i);
    if (!tbl_patched[i] || mem_wr_addr_q.size() >= bpt_pkg::MAX_OUT) return;
    mem_wr_addr_q.push_back(tbl_addr[i]);
    mem_wr_data_q.push_back(tbl_saved[i]);
    tbl_patched[i] = 1'b0;
  endtask

  task automatic clear_resume();
    resume_armed = 1'b0;
    resume_slot  = 0;
    auto_on      = 1'b0;
  endtask

  // Apply one request to the shadow table and queue the results it owes
  task automatic predict_table_update(input bp_req_t r);
    bpt_pkg::status_t st;
    logic             hit_f;
    logic [3:0]       hidx;
    int               s;
    int               n;
    bpt_pkg::rsp_t    rsp;
    st    = bpt_pkg::STS_OK;
    hit_f = 1'b0;
    hidx  = '0;
    mem_wr_addr_q.delete();
    mem_wr_data_q.delete();
    case (r.code)
      bpt_pkg::REQ_ADD: begin
        if (find_live_slot(r.addr) < 0) begin
          if (r.kind > bpt_pkg::KIND_MAX) begin
            st = bpt_pkg::STS_BAD_KIND;
          end else begin
            // reuse the first dead slot, else append
            s = -1;
            for (int i = 0; i < tbl_used; i++)
              if (s < 0 && !tbl_live[i]) s = i;
            if (s < 0 && tbl_used >= bpt_pkg::NUM_SLOTS) begin
              st = bpt_pkg::STS_FULL;
            end else begin
              if (s < 0) begin
                s = tbl_used;
                tbl_used++;
              end
              tbl_addr[s]    = r.addr;
              tbl_saved[s]   = r.orig;
              tbl_live[s]    = 1'b1;
              tbl_patched[s] = 1'b0;
              emit_trap(s);
            end
          end
        end
      end
      bpt_pkg::REQ_REMOVE: begin
        s = find_live_slot(r.addr);
        if (s < 0) begin
          st = bpt_pkg::STS_NOT_FOUND;
        end else begin
          emit_restore(s);
          tbl_live[s]    = 1'b0;
          tbl_patched[s] = 1'b0;
          if (resume_armed && resume_slot == s) clear_resume();
        end
      end
      bpt_pkg::REQ_LOOKUP: begin
        s = find_live_slot(r.addr);
        if (s < 0) begin
          st = bpt_pkg::STS_NOT_FOUND;
        end else begin
          hit_f = 1'b1;
          hidx  = s[3:0];
        end
      end
      bpt_pkg::REQ_INSERT, bpt_pkg::REQ_RESTORE: begin
        // slots at address zero are left alone by both walks
        for (int i = 0; i < tbl_used && mem_wr_addr_q.size() < bpt_pkg::MAX_OUT; i++) begin
          if (tbl_live[i] && tbl_addr[i] != '0) begin
            if (r.code == bpt_pkg::REQ_INSERT) emit_trap(i);
            else emit_restore(i);
          end
        end
      end
      bpt_pkg::REQ_PREPARE: begin
        s = find_live_slot(r.addr);
        if (s < 0) begin
          st = bpt_pkg::STS_NOT_FOUND;
        end else begin
          emit_restore(s);
          resume_armed = 1'b1;
          resume_slot  = s;
          auto_on      = 1'b0;
        end
      end
      bpt_pkg::REQ_FINISH: begin
        if (!resume_armed) begin
          st = bpt_pkg::STS_NOT_FOUND;
        end else begin
          emit_trap(resume_slot);
          clear_resume();
        end
      end
      bpt_pkg::REQ_CANCEL:  clear_resume();
      bpt_pkg::REQ_SETAUTO: auto_on = r.flag;
      default: ;
    endcase

    case (st)
      bpt_pkg::STS_FULL:      n_full++;
      bpt_pkg::STS_BAD_KIND:  n_bad_kind++;
      bpt_pkg::STS_NOT_FOUND: n_not_found++;
      default: ;
    endcase
    if (hit_f) n_hits++;
    n_writes += mem_wr_addr_q.size();

    // one item per write, or a single item without one
    n = (mem_wr_addr_q.size() > 0) ? mem_wr_addr_q.size() : 1;
    for (int k = 0; k < n; k++) begin
      rsp.status         = st;
      rsp.hit            = hit_f;
      rsp.hit_index      = hidx;
      rsp.wr_valid       = (mem_wr_addr_q.size() > 0);
      rsp.wr_addr        = rsp.wr_valid ? mem_wr_addr_q[k] : '0;
      rsp.wr_data        = rsp.wr_valid ? mem_wr_data_q[k] : '0;
      rsp.resume_pending = resume_armed;
      rsp.auto_resume    = auto_on;
      rsp.last           = (k == n - 1);
      expected_rsp_q.push_back(rsp);
    end
  endtask

  // Compare one result item against the oldest expectation
  task automatic check_result();
    bpt_pkg::rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch("unexpected result item", '0, rsp_if.wr_addr);
      return;
    end
    want = expected_rsp_q.pop_front();
    compare_field("status",         32'(want.status),         32'(rsp_if.status));
    compare_field("hit",            32'(want.hit),            32'(rsp_if.hit));
    compare_field("hit_index",      32'(want.hit_index),      32'(rsp_if.hit_index));
    compare_field("wr_valid",       32'(want.wr_valid),       32'(rsp_if.wr_valid));
    compare_field("wr_addr",        want.wr_addr,             rsp_if.wr_addr);
    compare_field("wr_data",        32'(want.wr_data),        32'(rsp_if.wr_data));
    compare_field("resume_pending", 32'(want.resume_pending), 32'(rsp_if.resume_pending));
    compare_field("auto_resume",    32'(want.auto_resume),    32'(rsp_if.auto_resume));
    compare_field("last",           32'(want.last),           32'(rsp_if.last));
  endtask

  task automatic queue_item(input logic [3:0] code, input logic [31:0] addr,
                            input logic [1:0] kind, input logic [7:0] orig,
                            input logic flag);
    bp_req_t it;
    it.code = code;
    it.addr = addr;
    it.kind = kind;
    it.orig = orig;
    it.flag = flag;
    it.gap  = no_gap ? 0 : $urandom_range(0, 9);
    item_q.push_back(it);
  endtask

  function automatic logic [1:0] draw_kind();
    if ($urandom_range(0, 99) < 85) return 2'($urandom_range(0, 1));
    return 2'($urandom_range(2, 3));
  endfunction

  // Driver: offer the next item at the falling edge, hold it until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_taken) gap_left = (item_q.size() > 0) ? item_q[0].gap : 0;
      if (req_if.valid && !req_taken) begin
        // hold the current item
      end else if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        req_if.req_type     <= item_q[0].code;
        req_if.target_addr  <= item_q[0].addr;
        req_if.bp_kind      <= item_q[0].kind;
        req_if.orig_byte_in <= item_q[0].orig;
        req_if.auto_flag_in <= item_q[0].flag;
        req_if.valid        <= 1'b1;
        void'(item_q.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls per item, with stall-free stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_taken) stall_left = (((n_rsp / 20) % 3) == 2) ? 0 : $urandom_range(0, 9);
      if (hold_cnt > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Long hold-off on the result side once, so the request side backs up
  always @(posedge clk) begin
    if (req_taken) hold_reqs <= hold_reqs + 1;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && hold_reqs >= 60) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin : monitor
    bp_req_t seen;
    req_taken <= rst_n && req_if.valid && req_if.ready;
    rsp_taken <= rst_n && rsp_if.valid && rsp_if.ready;
    if (rst_n && req_if.valid && req_if.ready) begin
      seen.code = req_if.req_type;
      seen.addr = req_if.target_addr;
      seen.kind = req_if.bp_kind;
      seen.orig = req_if.orig_byte_in;
      seen.flag = req_if.auto_flag_in;
      seen.gap  = 0;
      predict_table_update(seen);
      n_req++;
    end
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      check_result();
      n_rsp++;
    end
    // watchdog on cycles without any handshake
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] a;
    int          pick;
    int          made;
    // known levels from time zero
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = '0;
    req_if.target_addr   = '0;
    req_if.bp_kind       = '0;
    req_if.orig_byte_in  = '0;
    req_if.auto_flag_in  = 1'b0;
    rsp_if.ready         = 1'b0;
    req_taken            = 1'b0;
    rsp_taken            = 1'b0;
    gap_left             = 0;
    stall_left           = 0;
    hold_cnt             = 0;
    hold_reqs            = 0;
    hold_done            = 1'b0;
    idle_cycles          = 0;
    no_gap               = 1'b0;
    err_cnt              = 0;
    n_req                = 0;
    n_rsp                = 0;
    n_writes             = 0;
    n_full               = 0;
    n_bad_kind           = 0;
    n_not_found          = 0;
    n_hits               = 0;
    for (int i = 0; i < bpt_pkg::NUM_SLOTS; i++) begin
      tbl_addr[i]    = '0;
      tbl_saved[i]   = '0;
      tbl_live[i]    = 1'b0;
      tbl_patched[i] = 1'b0;
    end
    tbl_used = 0;
    clear_resume();

    // Directed: empty-table misses, kind checks, duplicates, walks, resume flows
    queue_item(bpt_pkg::REQ_FINISH,  32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_LOOKUP,  32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_REMOVE,  32'h0000_1000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_PREPARE, 32'h0000_1000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_ADD,     32'hFFFF_FFFF, 2'd1, 8'hFF, 1'b1);
    queue_item(bpt_pkg::REQ_ADD,     32'hFFFF_FFFF, 2'd3, 8'h11, 1'b0);
    queue_item(bpt_pkg::REQ_ADD,     32'h0000_1000, 2'd2, 8'h22, 1'b0);
    queue_item(bpt_pkg::REQ_ADD,     32'h0000_1000, 2'd3, 8'h33, 1'b0);
    queue_item(bpt_pkg::REQ_ADD,     32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_ADD,     32'h5555_AAAA, 2'd0, 8'h5A, 1'b0);
    queue_item(bpt_pkg::REQ_LOOKUP,  32'h5555_AAAA, 2'd3, 8'hFF, 1'b1);
    queue_item(bpt_pkg::REQ_RESTORE, 32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_INSERT,  32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_PREPARE, 32'hFFFF_FFFF, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_SETAUTO, 32'h0000_0000, 2'd0, 8'h00, 1'b1);
    queue_item(bpt_pkg::REQ_FINISH,  32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_SETAUTO, 32'h0000_0000, 2'd0, 8'h00, 1'b1);
    queue_item(bpt_pkg::REQ_PREPARE, 32'h5555_AAAA, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_CANCEL,  32'h0000_0000, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_PREPARE, 32'h5555_AAAA, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_REMOVE,  32'h5555_AAAA, 2'd0, 8'h00, 1'b0);
    queue_item(bpt_pkg::REQ_ADD,     32'h8000_0001, 2'd0, 8'hA5, 1'b0);
    queue_item(REQ_UNDEF_HI,         32'hFFFF_FFFF, 2'd3, 8'hFF, 1'b1);
    queue_item(REQ_UNDEF_LO,         32'h0000_0000, 2'd0, 8'h00, 1'b1);
    queue_item(bpt_pkg::REQ_LOOKUP,  32'h8000_0001, 2'd0, 8'h00, 1'b0);

    // Address pool small enough to hit and large enough to fill the table
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = $urandom;

    // Random: mostly well-formed request sequences, some noise
    made = 0;
    while (made < RANDOM_ITEMS) begin
      no_gap = (((made / 20) % 3) == 1);
      pick   = $urandom_range(0, 99);
      a      = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 40) begin
        queue_item(bpt_pkg::REQ_ADD, a, draw_kind(), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 52) begin
        queue_item(bpt_pkg::REQ_LOOKUP, a, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 62) begin
        queue_item(bpt_pkg::REQ_REMOVE, a, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 74) begin
        // prepare, maybe set auto-continue, then finish or cancel
        queue_item(bpt_pkg::REQ_PREPARE, a, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
        if ($urandom_range(0, 1)) begin
          queue_item(bpt_pkg::REQ_SETAUTO, $urandom, 2'($urandom), 8'($urandom),
                     1'($urandom));
          made++;
        end
        if ($urandom_range(0, 9) < 7)
          queue_item(bpt_pkg::REQ_FINISH, $urandom, 2'($urandom), 8'($urandom),
                     1'($urandom));
        else
          queue_item(bpt_pkg::REQ_CANCEL, $urandom, 2'($urandom), 8'($urandom),
                     1'($urandom));
        made++;
      end else if (pick < 81) begin
        queue_item(bpt_pkg::REQ_INSERT, $urandom, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 88) begin
        queue_item(bpt_pkg::REQ_RESTORE, $urandom, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 92) begin
        queue_item(bpt_pkg::REQ_SETAUTO, $urandom, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 94) begin
        queue_item(bpt_pkg::REQ_FINISH, $urandom, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 96) begin
        queue_item(bpt_pkg::REQ_CANCEL, $urandom, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else if (pick < 98) begin
        queue_item(4'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI)), $urandom,
                   2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end else begin
        queue_item(4'($urandom), $urandom, 2'($urandom), 8'($urandom), 1'($urandom));
        made++;
      end
    end

    // Release reset and let the driver run
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Drain, then give stray results a chance to show up
    @(negedge clk);
    while (item_q.size() > 0 || req_if.valid || expected_rsp_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsp_q.size() > 0)
      report_mismatch("results never delivered", 32'(expected_rsp_q.size()), '0);

    $display("Ran %0d requests giving %0d results with %0d memory writes.",
             n_req, n_rsp, n_writes);
    $display("Seen: %0d table full, %0d bad kind, %0d not found, %0d lookup hits.",
             n_full, n_bad_kind, n_not_found, n_hits);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: breakpoint_table_manager.f
hdl/bpt_pkg.sv
hdl/bpt_if.sv
hdl/bpt_table.sv
hdl/breakpoint_table_manager.sv
tb/sv/tb_breakpoint_table_manager.sv
